[rtl/xfa_pkg.sv]
// Shared types and constants of the 8/16-bit flag ALU.
package xfa_pkg;

    typedef enum logic [4:0] {
        OP_ADD   = 5'd0,
        OP_ADC   = 5'd1,
        OP_SUB   = 5'd2,
        OP_SBB   = 5'd3,
        OP_CMP   = 5'd4,
        OP_AND   = 5'd5,
        OP_OR    = 5'd6,
        OP_XOR   = 5'd7,
        OP_TEST  = 5'd8,
        OP_INC   = 5'd9,
        OP_DEC   = 5'd10,
        OP_NEG   = 5'd11,
        OP_NOT   = 5'd12,
        OP_RCL   = 5'd13,
        OP_RCR   = 5'd14,
        OP_ROL   = 5'd15,
        OP_ROR   = 5'd16,
        OP_SHL   = 5'd17,
        OP_SHR   = 5'd18,
        OP_SAR   = 5'd19,
        OP_SHLD  = 5'd20,
        OP_MUL   = 5'd21,
        OP_IMUL  = 5'd22,
        OP_IMUL2 = 5'd23,
        OP_DIV   = 5'd24,
        OP_IDIV  = 5'd25,
        OP_DAS   = 5'd26,
        OP_SEXT  = 5'd27
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_DIV_ZERO = 2'd1,
        ST_QUOT_OVF = 2'd2
    } t_status;

    typedef enum logic {
        CLS_SINGLE = 1'b0,
        CLS_DIVIDE = 1'b1
    } t_cls;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_DIV  = 1'b1
    } t_back_state;

    localparam logic [7:0] DAS_LIMIT = 8'h99;
    localparam logic [7:0] DAS_HIGH  = 8'h60;
    localparam logic [7:0] DAS_LOW   = 8'h06;

    typedef struct packed {
        logic [4:0]  operation;
        logic        wide;
        logic [15:0] operand_a;
        logic [15:0] operand_b;
        logic [15:0] operand_high;
        logic [15:0] shift_count;
    } t_in_word;

    typedef struct packed {
        logic [15:0] result_low;
        logic [15:0] result_high;
        logic        carry_out;
        logic        zero_out;
        logic        sign_out;
        logic        overflow_out;
        logic [1:0]  status;
    } t_out_word;

    typedef struct packed {
        t_in_word   item;
        t_cls       cls;
        logic [4:0] rc_count;
    } t_q_word;

    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [15:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [31:0] quotient;
        logic [15:0] remainder;
    } t_div_rsp;

    typedef struct packed {
        logic c;
        logic z;
        logic s;
        logic o;
    } t_flags;

endpackage

[rtl/xfa_front.sv]
// Front end: classify incoming words and hold them in a two-entry queue.
module xfa_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  xfa_pkg::t_in_word i_item,
    output logic             o_full,
    output logic             o_head_valid,
    output xfa_pkg::t_q_word o_head,
    input  logic             i_pop
);

    // x mod 9 for 8-bit x: reciprocal estimate, one correction
    function automatic logic [4:0] mod9(input logic [7:0] x);
        logic [16:0] prod;
        logic [4:0]  q;
        logic [8:0]  r;
        prod = {9'd0, x} * 17'd455;
        q    = prod[16:12];
        r    = {1'b0, x} - 9'({q, 3'b000} + {4'd0, q});
        if (r >= 9'd9) begin
            r = r - 9'd9;
        end
        return r[4:0];
    endfunction

    // x mod 17 for 16-bit x
    function automatic logic [4:0] mod17(input logic [15:0] x);
        logic [31:0] prod;
        logic [11:0] q;
        logic [16:0] r;
        prod = {16'd0, x} * 32'd61680;
        q    = prod[31:20];
        r    = {1'b0, x} - 17'({q, 4'b0000} + {4'd0, q});
        if (r >= 17'd17) begin
            r = r - 17'd17;
        end
        return r[4:0];
    endfunction

    xfa_pkg::t_q_word r_mem [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_count;
    xfa_pkg::t_q_word w_entry;
    logic             w_wr;
    logic             w_rd;

    always_comb begin
        w_entry.item = i_item;
        if (xfa_pkg::t_op'(i_item.operation) inside {xfa_pkg::OP_DIV, xfa_pkg::OP_IDIV}) begin
            w_entry.cls = xfa_pkg::CLS_DIVIDE;
        end else begin
            w_entry.cls = xfa_pkg::CLS_SINGLE;
        end
        if (!i_item.wide) begin
            w_entry.rc_count = mod9(i_item.shift_count[7:0]);
        end else if (xfa_pkg::t_op'(i_item.operation) == xfa_pkg::OP_RCR) begin
            w_entry.rc_count = mod17(i_item.shift_count);
        end else begin
            w_entry.rc_count = mod17({8'd0, i_item.shift_count[7:0]});
        end
    end

    assign o_full       = (r_count == 2'd2);
    assign o_head_valid = (r_count != 2'd0);
    assign o_head       = r_mem[r_rd_ptr];
    assign w_wr         = i_push && !o_full;
    assign w_rd         = i_pop && o_head_valid;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= w_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_rd) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + {1'b0, w_wr} - {1'b0, w_rd};
        end
    end

endmodule

[rtl/xfa_div.sv]
// Bit-serial restoring divider, 32-bit dividend by 16-bit divisor.
module xfa_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  xfa_pkg::t_div_req i_req,
    output xfa_pkg::t_div_rsp o_rsp
);

    logic [31:0] r_num;
    logic [15:0] r_rem;
    logic [15:0] r_dvs;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [16:0] w_sh;
    logic [16:0] w_diff;
    logic        w_bit;

    assign w_sh   = {r_rem, r_num[31]};
    assign w_diff = w_sh - {1'b0, r_dvs};
    assign w_bit  = (w_sh >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num <= i_req.dividend;
            r_rem <= 16'd0;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_num <= {r_num[30:0], w_bit};
            r_rem <= w_bit ? w_diff[15:0] : w_sh[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= 5'd0;
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (i_req.start) begin
            r_cnt  <= 5'd0;
            r_busy <= 1'b1;
            r_done <= 1'b0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 5'd1;
            if (r_cnt == 5'd31) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_num;
    assign o_rsp.remainder = r_rem;

endmodule

[rtl/xfa_back.sv]
// Back end: execute queued words, keep the flags, register the result.
module xfa_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_head_valid,
    input  xfa_pkg::t_q_word  i_head,
    output logic              o_pop,
    output logic              o_empty,
    output xfa_pkg::t_out_word o_result,
    input  logic              i_pop
);

    function automatic logic msb(input logic [15:0] x, input logic w);
        return w ? x[15] : x[7];
    endfunction

    function automatic logic sec(input logic [15:0] x, input logic w);
        return w ? x[14] : x[6];
    endfunction

    xfa_pkg::t_back_state r_state;
    xfa_pkg::t_back_state n_state;
    xfa_pkg::t_flags      r_flags;
    xfa_pkg::t_flags      n_flags;
    logic                 r_out_valid;
    xfa_pkg::t_out_word   r_out;
    xfa_pkg::t_div_req    w_req;
    xfa_pkg::t_div_rsp    w_rsp;

    logic        w_out_free;
    logic        w_load;
    logic        w_start;
    logic        w_div_run;
    logic        w_wide;
    logic        w_cf;
    logic [15:0] w_a;
    logic [15:0] w_b;
    logic [15:0] w_av;
    logic [15:0] w_bv;
    logic [15:0] w_m;
    logic [15:0] w_sb;
    logic [4:0]  w_w;
    logic [7:0]  w_c8;
    logic [31:0] w_av32;
    logic [16:0] w_ma;
    logic [16:0] w_mb;
    logic [33:0] w_prod;
    logic [31:0] w_p;
    logic        w_sn;
    logic        w_sd;
    logic [31:0] w_num;
    logic [15:0] w_dmag;

    logic [15:0] res_lo;
    logic [15:0] res_hi;
    logic [1:0]  res_st;
    logic [15:0] r16;
    logic [31:0] t32;
    logic [31:0] t2;
    logic [47:0] w48;
    logic [15:0] mask16;
    logic [4:0]  c5;
    logic [7:0]  csat;
    logic [7:0]  al;
    logic        qneg;
    logic [31:0] qv;
    logic [15:0] rv;
    logic        ovf;

    assign w_wide = i_head.item.wide;
    assign w_a    = i_head.item.operand_a;
    assign w_b    = i_head.item.operand_b;
    assign w_m    = w_wide ? 16'hFFFF : 16'h00FF;
    assign w_sb   = w_wide ? 16'h8000 : 16'h0080;
    assign w_w    = w_wide ? 5'd16 : 5'd8;
    assign w_av   = w_a & w_m;
    assign w_bv   = w_b & w_m;
    assign w_c8   = i_head.item.shift_count[7:0];
    assign w_cf   = r_flags.c;
    assign w_av32 = {16'd0, w_av};

    assign w_div_run = (i_head.cls == xfa_pkg::CLS_DIVIDE) && (w_bv != 16'd0);
    assign w_out_free = !r_out_valid || i_pop;

    // single shared multiplier, operands prepared per operation
    always_comb begin
        w_ma = {1'b0, w_av};
        w_mb = {1'b0, w_bv};
        if (xfa_pkg::t_op'(i_head.item.operation) == xfa_pkg::OP_IMUL) begin
            w_ma = w_wide ? {w_a[15], w_a} : {{9{w_a[7]}}, w_a[7:0]};
            w_mb = w_wide ? {w_b[15], w_b} : {{9{w_b[7]}}, w_b[7:0]};
        end else if (xfa_pkg::t_op'(i_head.item.operation) == xfa_pkg::OP_IMUL2) begin
            w_ma = {1'b0, w_a};
            w_mb = {1'b0, w_b};
        end
    end
    assign w_prod = $signed(w_ma) * $signed(w_mb);
    assign w_p    = w_prod[31:0];

    // divider operands as magnitudes; signs restored on the way out
    always_comb begin
        w_sd = 1'b0;
        w_sn = 1'b0;
        w_num = w_wide ? {i_head.item.operand_high, w_a} : {16'd0, w_a};
        if (xfa_pkg::t_op'(i_head.item.operation) == xfa_pkg::OP_IDIV) begin
            w_sd = msb(w_bv, w_wide);
            if (!w_wide) begin
                w_num = {{16{w_a[15]}}, w_a};
            end
            w_sn = w_num[31];
        end
        if (w_sn) begin
            w_num = 32'd0 - w_num;
        end
        w_dmag = w_sd ? ((16'd0 - w_bv) & w_m) : w_bv;
    end

    assign w_req.start    = w_start;
    assign w_req.dividend = w_num;
    assign w_req.divisor  = w_dmag;

    xfa_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    // execute
    always_comb begin
        n_flags = r_flags;
        res_lo  = 16'd0;
        res_hi  = 16'd0;
        res_st  = xfa_pkg::ST_OK;
        r16     = 16'd0;
        t32     = 32'd0;
        t2      = 32'd0;
        w48     = 48'd0;
        mask16  = 16'd0;
        c5      = 5'd0;
        csat    = 8'd0;
        al      = 8'd0;
        qneg    = 1'b0;
        qv      = 32'd0;
        rv      = 16'd0;
        ovf     = 1'b0;
        case (xfa_pkg::t_op'(i_head.item.operation))
            xfa_pkg::OP_ADD: begin
                r16 = (w_av + w_bv) & w_m;
                n_flags.c = (r16 < w_av);
                n_flags.o = |((w_av ^ w_bv ^ w_sb) & (r16 ^ w_bv) & w_sb);
                n_flags.z = (r16 == 16'd0);
                n_flags.s = |(r16 & w_sb);
                res_lo = r16;
            end
            xfa_pkg::OP_ADC: begin
                r16 = (w_av + w_bv + {15'd0, w_cf}) & w_m;
                n_flags.c = (r16 < w_av) || (w_cf && (r16 == w_av));
                n_flags.o = |((w_av ^ w_bv ^ w_sb) & (r16 ^ w_bv) & w_sb);
                n_flags.z = (r16 == 16'd0);
                n_flags.s = |(r16 & w_sb);
                res_lo = r16;
            end
            xfa_pkg::OP_SUB, xfa_pkg::OP_CMP: begin
                r16 = (w_av - w_bv) & w_m;
                n_flags.c = (w_av < w_bv);
                n_flags.o = |((w_av ^ w_bv) & (w_av ^ r16) & w_sb);
                n_flags.z = (r16 == 16'd0);
                n_flags.s = |(r16 & w_sb);
                res_lo = r16;
            end
            xfa_pkg::OP_SBB: begin
                r16 = (w_av - w_bv - {15'd0, w_cf}) & w_m;
                n_flags.c = (w_av < r16) || (w_cf && (w_bv == w_m));
                n_flags.o = |((w_av ^ w_bv) & (w_av ^ r16) & w_sb);
                n_flags.z = (r16 == 16'd0);
                n_flags.s = |(r16 & w_sb);
                res_lo = r16;
            end
            xfa_pkg::OP_AND, xfa_pkg::OP_OR, xfa_pkg::OP_XOR, xfa_pkg::OP_TEST: begin
                if (xfa_pkg::t_op'(i_head.item.operation) == xfa_pkg::OP_OR) begin
                    r16 = w_av | w_bv;
                end else if (xfa_pkg::t_op'(i_head.item.operation) == xfa_pkg::OP_XOR) begin
                    r16 = w_av ^ w_bv;
                end else begin
                    r16 = w_av & w_bv;
                end
                n_flags.c = 1'b0;
                n_flags.o = 1'b0;
                n_flags.z = (r16 == 16'd0);
                n_flags.s = |(r16 & w_sb);
                res_lo = r16;
            end
            xfa_pkg::OP_INC: begin
                r16 = (w_av + 16'd1) & w_m;
                n_flags.o = (r16 == w_sb);
                n_flags.z = (r16 == 16'd0);
                n_flags.s = |(r16 & w_sb);
                res_lo = r16;
            end
            xfa_pkg::OP_DEC: begin
                r16 = (w_av - 16'd1) & w_m;
                n_flags.o = (r16 == (w_sb - 16'd1));
                n_flags.z = (r16 == 16'd0);
                n_flags.s = |(r16 & w_sb);
                res_lo = r16;
            end
            xfa_pkg::OP_NEG: begin
                r16 = (16'd0 - w_av) & w_m;
                n_flags.c = (w_av != 16'd0);
                n_flags.z = (r16 == 16'd0);
                n_flags.s = |(w_av & w_sb);
                n_flags.o = (w_av == w_sb);
                res_lo = r16;
            end
            xfa_pkg::OP_NOT: begin
                res_lo = ~w_av & w_m;
            end
            xfa_pkg::OP_RCL: begin
                c5 = i_head.rc_count;
                res_lo = w_av;
                if (c5 != 5'd0) begin
                    t32 = (w_av32 << c5) | ({31'd0, w_cf} << (c5 - 5'd1))
                        | (w_av32 >> (6'(w_w) + 6'd1 - 6'(c5)));
                    r16 = t32[15:0] & w_m;
                    t2  = w_av32 >> (6'(w_w) - 6'(c5));
                    n_flags.o = w_cf ^ msb(r16, w_wide);
                    n_flags.c = t2[0];
                    res_lo = r16;
                end
            end
            xfa_pkg::OP_RCR: begin
                c5 = i_head.rc_count;
                res_lo = w_av;
                if (c5 != 5'd0) begin
                    t32 = (w_av32 >> c5) | ({31'd0, w_cf} << (6'(w_w) - 6'(c5)))
                        | (w_av32 << (6'(w_w) + 6'd1 - 6'(c5)));
                    r16 = t32[15:0] & w_m;
                    t2  = w_av32 >> (c5 - 5'd1);
                    n_flags.c = t2[0];
                    n_flags.o = msb(r16, w_wide) ^ sec(r16, w_wide);
                    res_lo = r16;
                end
            end
            xfa_pkg::OP_ROL, xfa_pkg::OP_ROR: begin
                c5 = w_wide ? {1'b0, w_c8[3:0]} : {2'b00, w_c8[2:0]};
                res_lo = w_av;
                if (c5 == 5'd0) begin
                    // count that is a whole number of turns still sets the flags
                    if ((w_c8 & (w_wide ? 8'h10 : 8'h18)) != 8'd0) begin
                        if (xfa_pkg::t_op'(i_head.item.operation) == xfa_pkg::OP_ROL) begin
                            n_flags.c = w_av[0];
                            n_flags.o = w_av[0] ^ msb(w_av, w_wide);
                        end else begin
                            n_flags.c = msb(w_av, w_wide);
                            n_flags.o = msb(w_av, w_wide) ^ sec(w_av, w_wide);
                        end
                    end
                end else if (xfa_pkg::t_op'(i_head.item.operation) == xfa_pkg::OP_ROL) begin
                    t32 = (w_av32 << c5) | (w_av32 >> (w_w - c5));
                    r16 = t32[15:0] & w_m;
                    n_flags.c = r16[0];
                    n_flags.o = r16[0] ^ msb(r16, w_wide);
                    res_lo = r16;
                end else begin
                    t32 = (w_av32 >> c5) | (w_av32 << (w_w - c5));
                    r16 = t32[15:0] & w_m;
                    n_flags.c = msb(r16, w_wide);
                    n_flags.o = msb(r16, w_wide) ^ sec(r16, w_wide);
                    res_lo = r16;
                end
            end
            xfa_pkg::OP_SHL: begin
                res_lo = w_av;
                if (w_c8 != 8'd0) begin
                    t32 = w_av32 << w_c8;
                    r16 = (w_c8 >= 8'(w_w)) ? 16'd0 : (t32[15:0] & w_m);
                    t2  = w_av32 >> (8'(w_w) - w_c8);
                    n_flags.c = (w_c8 > 8'(w_w)) ? 1'b0 : t2[0];
                    n_flags.o = msb(r16 ^ w_av, w_wide);
                    n_flags.z = (r16 == 16'd0);
                    n_flags.s = |(r16 & w_sb);
                    res_lo = r16;
                end
            end
            xfa_pkg::OP_SHR: begin
                res_lo = w_av;
                if (w_c8 != 8'd0) begin
                    t32 = w_av32 >> w_c8;
                    r16 = (w_c8 >= 8'(w_w)) ? 16'd0 : t32[15:0];
                    t2  = w_av32 >> (w_c8 - 8'd1);
                    n_flags.c = (w_c8 > 8'(w_w)) ? 1'b0 : t2[0];
                    n_flags.o = (w_c8[4:0] == 5'd1) ? (w_av > w_sb) : 1'b0;
                    n_flags.z = (r16 == 16'd0);
                    n_flags.s = |(r16 & w_sb);
                    res_lo = r16;
                end
            end
            xfa_pkg::OP_SAR: begin
                res_lo = w_av;
                if (w_c8 != 8'd0) begin
                    csat = (w_c8 > 8'(w_w)) ? 8'(w_w) : w_c8;
                    t32  = w_av32 >> csat;
                    r16  = t32[15:0];
                    if (msb(w_av, w_wide)) begin
                        t2  = {16'd0, w_m} << (8'(w_w) - csat);
                        r16 = r16 | (t2[15:0] & w_m);
                    end
                    t2 = w_av32 >> (csat - 8'd1);
                    n_flags.c = t2[0];
                    n_flags.o = 1'b0;
                    n_flags.z = (r16 == 16'd0);
                    n_flags.s = |(r16 & w_sb);
                    res_lo = r16;
                end
            end
            xfa_pkg::OP_SHLD: begin
                c5 = w_c8[4:0];
                res_lo = w_a;
                if (c5 != 5'd0) begin
                    t32    = (32'd1 << c5) - 32'd1;
                    mask16 = t32[15:0];
                    w48    = ({32'd0, w_a} << c5) | {32'd0, w_b & mask16};
                    n_flags.c = w48[16];
                    n_flags.z = (w48[15:0] == 16'd0);
                    n_flags.s = w48[15];
                    res_lo = w48[15:0];
                end
            end
            xfa_pkg::OP_MUL: begin
                res_lo = w_p[15:0] & w_m;
                res_hi = w_wide ? w_p[31:16] : {8'd0, w_p[15:8]};
                n_flags.z = (res_lo == 16'd0);
                n_flags.c = (res_hi != 16'd0);
                n_flags.o = (res_hi != 16'd0);
            end
            xfa_pkg::OP_IMUL: begin
                if (w_wide) begin
                    ovf = !((&w_p[31:15]) || !(|w_p[31:15]));
                end else begin
                    ovf = !((&w_p[15:7]) || !(|w_p[15:7]));
                end
                n_flags.c = ovf;
                n_flags.o = ovf;
                res_lo = w_p[15:0] & w_m;
                res_hi = w_wide ? w_p[31:16] : {8'd0, w_p[15:8]};
            end
            xfa_pkg::OP_IMUL2: begin
                ovf = !((&w_p[31:15]) || !(|w_p[31:15]));
                n_flags.c = ovf;
                n_flags.o = ovf;
                res_lo = w_p[15:0];
            end
            xfa_pkg::OP_DIV, xfa_pkg::OP_IDIV: begin
                if (w_bv == 16'd0) begin
                    res_st = xfa_pkg::ST_DIV_ZERO;
                end else begin
                    if (xfa_pkg::t_op'(i_head.item.operation) == xfa_pkg::OP_DIV) begin
                        ovf = w_wide ? (|w_rsp.quotient[31:16]) : (|w_rsp.quotient[31:8]);
                    end else begin
                        qneg = w_sn ^ w_sd;
                        ovf  = qneg ? (w_rsp.quotient > {16'd0, w_sb})
                                    : (w_rsp.quotient > {16'd0, w_sb - 16'd1});
                    end
                    qv = qneg ? (32'd0 - w_rsp.quotient) : w_rsp.quotient;
                    rv = w_sn ? (16'd0 - w_rsp.remainder) : w_rsp.remainder;
                    if (ovf) begin
                        res_st = xfa_pkg::ST_QUOT_OVF;
                    end else begin
                        res_lo = qv[15:0] & w_m;
                        res_hi = rv & w_m;
                    end
                end
            end
            xfa_pkg::OP_DAS: begin
                al = w_a[7:0];
                if (al[3:0] > 4'd9) begin
                    if ((al > xfa_pkg::DAS_LIMIT) || w_cf) begin
                        al = al - xfa_pkg::DAS_HIGH;
                        n_flags.c = 1'b1;
                    end else begin
                        n_flags.c = (al <= 8'h05);
                    end
                    al = al - xfa_pkg::DAS_LOW;
                end else if ((al > xfa_pkg::DAS_LIMIT) || w_cf) begin
                    al = al - xfa_pkg::DAS_HIGH;
                    n_flags.c = 1'b1;
                end else begin
                    n_flags.c = 1'b0;
                end
                n_flags.o = w_a[7] && !al[7];
                n_flags.z = (al == 8'd0);
                n_flags.s = al[7];
                res_lo = {8'd0, al};
            end
            xfa_pkg::OP_SEXT: begin
                res_lo = w_av;
                res_hi = msb(w_av, w_wide) ? w_m : 16'd0;
            end
            default: begin
                res_lo = 16'd0;
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            xfa_pkg::S_IDLE: begin
                if (i_head_valid && w_out_free && w_div_run) begin
                    n_state = xfa_pkg::S_DIV;
                end
            end
            xfa_pkg::S_DIV: begin
                if (w_rsp.done && w_out_free) begin
                    n_state = xfa_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = xfa_pkg::S_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        w_start = 1'b0;
        w_load  = 1'b0;
        case (r_state)
            xfa_pkg::S_IDLE: begin
                if (i_head_valid && w_out_free) begin
                    w_start = w_div_run;
                    w_load  = !w_div_run;
                end
            end
            xfa_pkg::S_DIV: begin
                w_load = w_rsp.done && w_out_free;
            end
            default: begin
                w_load = 1'b0;
            end
        endcase
    end

    assign o_pop = w_load;

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out.result_low   <= res_lo;
            r_out.result_high  <= res_hi;
            r_out.carry_out    <= n_flags.c;
            r_out.zero_out     <= n_flags.z;
            r_out.sign_out     <= n_flags.s;
            r_out.overflow_out <= n_flags.o;
            r_out.status       <= res_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= xfa_pkg::S_IDLE;
            r_flags     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_flags     <= n_flags;
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_empty  = !r_out_valid;
    assign o_result = r_out;

endmodule

[rtl/x86_flag_alu_8_16.sv]
// Flow: an accepted word waits in the queue and is executed from its head into the result
// register; div and idiv with a nonzero divisor first run the serial divider.
// Throughput: one word per cycle for every operation except div and idiv while the result
// register is free; div and idiv hold the back end until the one-bit-per-cycle divider is done.
// Reset: synchronous, active low; clears the four flags, the queue and the result valid.
// Top level of the 8/16-bit flag ALU.
module x86_flag_alu_8_16 (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  xfa_pkg::t_in_word  i_item,
    output logic               empty,
    input  logic               pop,
    output xfa_pkg::t_out_word o_result
);

    // front to back: head of the two-word queue and its pop
    logic             w_head_valid;
    xfa_pkg::t_q_word w_head;
    logic             w_q_pop;

    // accept and classify; the queue lets the front keep taking words during a divide
    xfa_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_item       (i_item),
        .o_full       (full),
        .o_head_valid (w_head_valid),
        .o_head       (w_head),
        .i_pop        (w_q_pop)
    );

    // execute in order, hold flags, advance into the result register
    xfa_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (w_head_valid),
        .i_head       (w_head),
        .o_pop        (w_q_pop),
        .o_empty      (empty),
        .o_result     (o_result),
        .i_pop        (pop)
    );

    // the back end only drops a queued word that is there
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_pop |-> w_head_valid)
        else $error("queue popped while empty");

    // a full queue always presents a head
    a_full_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> w_head_valid)
        else $error("queue full without head");

    // a divide error returns zero halves
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_result.status != xfa_pkg::ST_OK))
            |-> ((o_result.result_low == 16'd0) && (o_result.result_high == 16'd0)))
        else $error("divide error with nonzero result");

endmodule

[bench/tb_top.sv]
// Self-checking bench for the 8/16-bit flag ALU: table of directed words, then random traffic.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import xfa_pkg::*;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      push = 1'b0;
    logic      pop = 1'b0;
    logic      full;
    logic      empty;
    t_in_word  i_item = '0;
    t_out_word o_result;

    x86_flag_alu_8_16 dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full),
        .i_item(i_item), .empty(empty), .pop(pop), .o_result(o_result)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Flag copy kept by the predictor; advanced once per accepted word.
    t_flags    alu_flags;
    t_out_word pending_results[$];
    int        fail_count = 0;
    bit        stim_done = 1'b0;
    bit        hold_pop = 1'b0;
    int        idle_cycles = 0;

    // Predict one word: returns the result and updates alu_flags.
    function automatic t_out_word alu_predict(t_in_word w);
        logic [31:0] a, b, hi, cnt, c8, msk, sb, wd, av, bv, r, c, p, hm, num, q;
        logic [63:0] wv;
        longint      sn, sd, sq, srm, lim;
        logic        cf, neg;
        t_out_word   o;
        t_flags      f;
        a = w.operand_a; b = w.operand_b; hi = w.operand_high; cnt = w.shift_count;
        c8 = cnt & 32'hFF;
        msk = w.wide ? 32'hFFFF : 32'hFF;
        sb = w.wide ? 32'h8000 : 32'h80;
        wd = w.wide ? 32'd16 : 32'd8;
        av = a & msk; bv = b & msk;
        f = alu_flags; cf = f.c;
        o = '0;
        r = 0; p = 0;
        case (w.operation)
            OP_ADD, OP_ADC: begin
                r = (av + bv + ((w.operation == OP_ADC) ? cf : 0)) & msk;
                f.c = (r < av) || (w.operation == OP_ADC && cf && r == av);
                f.o = ((av ^ bv ^ sb) & (r ^ bv) & sb) != 0;
                f.z = r == 0; f.s = (r & sb) != 0; o.result_low = r;
            end
            OP_SUB, OP_CMP: begin
                r = (av - bv) & msk; f.c = av < bv;
                f.o = ((av ^ bv) & (av ^ r) & sb) != 0;
                f.z = r == 0; f.s = (r & sb) != 0; o.result_low = r;
            end
            OP_SBB: begin
                r = (av - bv - cf) & msk;
                f.c = (av < r) || (cf && bv == msk);
                f.o = ((av ^ bv) & (av ^ r) & sb) != 0;
                f.z = r == 0; f.s = (r & sb) != 0; o.result_low = r;
            end
            OP_AND, OP_OR, OP_XOR, OP_TEST: begin
                r = (w.operation == OP_OR) ? (av | bv) :
                    (w.operation == OP_XOR) ? (av ^ bv) : (av & bv);
                f.c = 0; f.o = 0; f.z = r == 0; f.s = (r & sb) != 0; o.result_low = r;
            end
            OP_INC, OP_DEC: begin
                r = (w.operation == OP_INC) ? ((av + 1) & msk) : ((av - 1) & msk);
                f.o = (w.operation == OP_INC) ? (r == sb) : (r == sb - 1);
                f.z = r == 0; f.s = (r & sb) != 0; o.result_low = r;
            end
            OP_NEG: begin
                r = (0 - av) & msk; f.c = av != 0; f.z = r == 0;
                f.s = (av & sb) != 0; f.o = av == sb; o.result_low = r;
            end
            OP_NOT: o.result_low = ~av & msk;
            OP_RCL: begin
                c = c8 % (wd + 1); o.result_low = av;
                if (c != 0) begin
                    r = ((av << c) | (cf << (c - 1)) | (av >> (wd + 1 - c))) & msk;
                    f.o = cf ^ r[wd - 1];
                    f.c = (av >> (wd - c)) & 1;
                    o.result_low = r;
                end
            end
            OP_RCR: begin
                c = (w.wide ? cnt : c8) % (wd + 1); o.result_low = av;
                if (c != 0) begin
                    r = ((av >> c) | (cf << (wd - c)) | (av << (wd + 1 - c))) & msk;
                    f.c = (av >> (c - 1)) & 1;
                    f.o = ((r ^ (r << 1)) & sb) != 0;
                    o.result_low = r;
                end
            end
            OP_ROL, OP_ROR: begin
                c = c8 & (wd - 1); o.result_low = av;
                if (c == 0) begin
                    if ((c8 & (w.wide ? 32'h10 : 32'h18)) != 0) begin
                        if (w.operation == OP_ROL) begin
                            f.c = av[0]; f.o = av[0] ^ av[wd - 1];
                        end else begin
                            f.c = av[wd - 1]; f.o = ((av ^ (av << 1)) & sb) != 0;
                        end
                    end
                end else if (w.operation == OP_ROL) begin
                    r = ((av << c) | (av >> (wd - c))) & msk;
                    f.c = r[0]; f.o = r[0] ^ r[wd - 1]; o.result_low = r;
                end else begin
                    r = ((av >> c) | (av << (wd - c))) & msk;
                    f.c = (r & sb) != 0; f.o = ((r ^ (r << 1)) & sb) != 0;
                    o.result_low = r;
                end
            end
            OP_SHL, OP_SHR, OP_SAR: begin
                o.result_low = av;
                if (c8 != 0) begin
                    if (w.operation == OP_SHL) begin
                        r = (c8 >= wd) ? 0 : ((av << c8) & msk);
                        f.c = (c8 > wd) ? 0 : ((av >> (wd - c8)) & 1);
                        f.o = ((r ^ av) & sb) != 0;
                    end else if (w.operation == OP_SHR) begin
                        r = (c8 >= wd) ? 0 : (av >> c8);
                        f.c = (c8 > wd) ? 0 : ((av >> (c8 - 1)) & 1);
                        f.o = ((c8 & 32'h1F) == 1) ? (av > sb) : 0;
                    end else begin
                        c = (c8 > wd) ? wd : c8;
                        r = av >> c;
                        if ((av & sb) != 0) r = r | ((msk << (wd - c)) & msk);
                        f.c = (av >> (c - 1)) & 1;
                        f.o = 0;
                    end
                    f.z = r == 0; f.s = (r & sb) != 0; o.result_low = r;
                end
            end
            OP_SHLD: begin
                c = c8 & 31; o.result_low = a;
                if (c != 0) begin
                    wv = (64'(a) << c) | 64'(b & ((32'd1 << c) - 1));
                    f.c = wv[16]; f.z = wv[15:0] == 0; f.s = wv[15];
                    o.result_low = wv[15:0];
                end
            end
            OP_MUL: begin
                p = av * bv;
                o.result_low = p & msk; o.result_high = (p >> wd) & msk;
                f.z = (p & msk) == 0;
                f.c = o.result_high != 0; f.o = f.c;
            end
            OP_IMUL: begin
                sn = w.wide ? longint'($signed(av[15:0])) : longint'($signed(av[7:0]));
                sd = w.wide ? longint'($signed(bv[15:0])) : longint'($signed(bv[7:0]));
                p = 32'(sn * sd);
                if (!w.wide) begin
                    p = p & 32'hFFFF; hm = p & 32'hFF80;
                    f.c = !(hm == 32'hFF80 || hm == 0);
                end else begin
                    hm = p & 32'hFFFF8000;
                    f.c = !(hm == 32'hFFFF8000 || hm == 0);
                end
                f.o = f.c;
                o.result_low = p & msk; o.result_high = (p >> wd) & msk;
            end
            OP_IMUL2: begin
                p = a * b; hm = p & 32'hFFFF8000;
                f.c = !(hm == 32'hFFFF8000 || hm == 0); f.o = f.c;
                o.result_low = p[15:0];
            end
            OP_DIV: begin
                if (bv == 0) o.status = ST_DIV_ZERO;
                else begin
                    num = w.wide ? ((hi << 16) | a) : a;
                    q = num / bv;
                    if (q > msk) o.status = ST_QUOT_OVF;
                    else begin
                        o.result_low = q; o.result_high = num % bv;
                    end
                end
            end
            OP_IDIV: begin
                if (bv == 0) o.status = ST_DIV_ZERO;
                else begin
                    sn = w.wide ? longint'($signed({hi[15:0], a[15:0]}))
                                : longint'($signed(a[15:0]));
                    sd = w.wide ? longint'($signed(bv[15:0])) : longint'($signed(bv[7:0]));
                    sq = sn / sd; srm = sn % sd; lim = longint'(sb);
                    if (sq < -lim || sq > lim - 1) o.status = ST_QUOT_OVF;
                    else begin
                        o.result_low = 32'(sq) & msk; o.result_high = 32'(srm) & msk;
                    end
                end
            end
            OP_DAS: begin
                r = a & 32'hFF; neg = r[7];
                if ((r & 32'hF) > 9) begin
                    if (r > DAS_LIMIT || cf) begin
                        r = (r - DAS_HIGH) & 32'hFF; f.c = 1;
                    end else f.c = r <= 5;
                    r = (r - DAS_LOW) & 32'hFF;
                end else begin
                    if (r > DAS_LIMIT || cf) begin
                        r = (r - DAS_HIGH) & 32'hFF; f.c = 1;
                    end else f.c = 0;
                end
                f.o = neg && !r[7]; f.z = r == 0; f.s = r[7];
                o.result_low = r;
            end
            OP_SEXT: begin
                o.result_low = av; o.result_high = ((av & sb) != 0) ? msk : 0;
            end
            default: ;
        endcase
        alu_flags = f;
        o.carry_out = f.c; o.zero_out = f.z; o.sign_out = f.s; o.overflow_out = f.o;
        return o;
    endfunction

    // Directed rows; when set, known_result is checked against the predictor's result for the row.
    typedef struct {
        t_in_word  w;
        bit        has_known;
        t_out_word known_result;
    } t_row;
    t_row directed_rows[$];

    function automatic t_in_word mk(t_op op, bit wd, int a, int b, int h, int c);
        t_in_word w;
        w.operation = op; w.wide = wd; w.operand_a = a[15:0]; w.operand_b = b[15:0];
        w.operand_high = h[15:0]; w.shift_count = c[15:0];
        return w;
    endfunction

    function automatic t_out_word res(int lo, int hh, bit c, bit z, bit s, bit o,
                                      t_status st);
        t_out_word r;
        r.result_low = lo[15:0]; r.result_high = hh[15:0]; r.carry_out = c;
        r.zero_out = z; r.sign_out = s; r.overflow_out = o; r.status = st;
        return r;
    endfunction

    task automatic add_row(t_in_word w, bit k = 0, t_out_word r = '0);
        t_row row;
        row.w = w; row.has_known = k; row.known_result = r;
        directed_rows.insert(directed_rows.size(), row);
    endtask

    function automatic t_in_word rand_word();
        t_in_word w;
        int sel;
        w = t_in_word'({$urandom, $urandom, $urandom});
        w.operation = 5'($urandom_range(0, 31));
        sel = $urandom_range(0, 9);
        // Keep most shift counts small so rotate and shift paths do real work.
        if (sel < 6) w.shift_count = 16'($urandom_range(0, 33));
        // Bias division toward results that fit, with some zero divisors.
        if ((w.operation == OP_DIV || w.operation == OP_IDIV) && sel < 7) begin
            w.operand_high = (sel < 4) ? 16'h0 : {16{w.operand_a[15]}};
            if (sel == 0) w.operand_b = 16'h0;
        end
        return w;
    endfunction

    // Push one word, stalling while the block is full.
    task automatic send_word(t_in_word w);
        push <= 1'b1;
        i_item <= w;
        do @(posedge i_clk); while (full);
        pending_results.insert(pending_results.size(), alu_predict(w));
    endtask

    task automatic idle_send();
        push <= 1'b0;
        @(posedge i_clk);
    endtask

    // Sender.
    initial begin
        t_out_word known;
        int        burst;
        int        k;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        alu_flags = '0;
        @(posedge i_clk);

        add_row(mk(OP_NOT, 0, 16'h00F0, 0, 0, 0), 1, res(16'h000F, 0, 0, 0, 0, 0, ST_OK));
        add_row(mk(OP_ADD, 1, 16'hFFFF, 16'h0001, 0, 0), 1, res(0, 0, 1, 1, 0, 0, ST_OK));
        add_row(mk(OP_ADC, 0, 16'h007F, 16'h0000, 0, 0), 1, res(16'h80, 0, 0, 0, 1, 1, ST_OK));
        add_row(mk(OP_SUB, 0, 16'h0000, 16'h0001, 0, 0), 1, res(16'hFF, 0, 1, 0, 1, 0, ST_OK));
        add_row(mk(OP_SBB, 1, 16'h8000, 16'hFFFF, 0, 0));
        add_row(mk(OP_CMP, 1, 16'h1234, 16'h1234, 0, 0));
        add_row(mk(OP_AND, 1, 16'hFFFF, 16'h8000, 0, 0));
        add_row(mk(OP_OR, 0, 16'h0000, 16'h0000, 0, 0));
        add_row(mk(OP_XOR, 1, 16'hAAAA, 16'h5555, 0, 0));
        add_row(mk(OP_TEST, 0, 16'hFF80, 16'h0080, 0, 0));
        add_row(mk(OP_INC, 1, 16'h7FFF, 0, 0, 0));
        add_row(mk(OP_DEC, 0, 16'h0080, 0, 0, 0));
        add_row(mk(OP_NEG, 0, 16'h0080, 0, 0, 0));
        add_row(mk(OP_RCL, 0, 16'h0081, 0, 0, 9));
        add_row(mk(OP_RCR, 1, 16'h8001, 0, 0, 16'hFF11));
        add_row(mk(OP_ROL, 0, 16'h0081, 0, 0, 16'h0010));
        add_row(mk(OP_ROR, 1, 16'h8001, 0, 0, 16'h0003));
        add_row(mk(OP_SHL, 0, 16'h00C1, 0, 0, 9));
        add_row(mk(OP_SHR, 1, 16'h8001, 0, 0, 16'h0021));
        add_row(mk(OP_SAR, 1, 16'h8000, 0, 0, 16'h00FF));
        add_row(mk(OP_SHLD, 1, 16'hFFFF, 16'hFFFF, 0, 31));
        add_row(mk(OP_MUL, 1, 16'hFFFF, 16'hFFFF, 0, 0));
        add_row(mk(OP_IMUL, 0, 16'h0080, 16'h0080, 0, 0));
        add_row(mk(OP_IMUL2, 1, 16'hFFFF, 16'h0002, 0, 0));
        add_row(mk(OP_DIV, 1, 16'h1234, 16'h0000, 16'hFFFF, 0), 1,
                res(0, 0, alu_flags.c, 0, 0, 0, ST_DIV_ZERO));
        add_row(mk(OP_IDIV, 1, 16'h0000, 16'hFFFF, 16'h8000, 0));
        add_row(mk(OP_DAS, 0, 16'h009A, 0, 0, 0));
        // Sign extension keeps the flags that the decimal adjust left behind.
        add_row(mk(OP_SEXT, 1, 16'h8000, 0, 0, 0), 1, res(16'h8000, 16'hFFFF, 1, 0, 0, 1, ST_OK));
        add_row(mk(t_op'(5'd31), 1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));

        foreach (directed_rows[i]) begin
            // Typed-in flags of the divide-by-zero row follow the flags before it.
            known = directed_rows[i].known_result;
            if (directed_rows[i].w.operation == OP_DIV) begin
                known.carry_out = alu_flags.c; known.zero_out = alu_flags.z;
                known.sign_out = alu_flags.s; known.overflow_out = alu_flags.o;
            end
            send_word(directed_rows[i].w);
            if (directed_rows[i].has_known && pending_results[$] !== known) begin
                $error("row %0d typed-in result: expected %h actual %h", i,
                       known, pending_results[$]);
                fail_count++;
            end
        end
        idle_send();

        // Drain pause: wait for every expected result.
        while (pending_results.size() != 0) @(posedge i_clk);

        k = 0;
        while (k < 1950) begin
            burst = $urandom_range(1, 40);
            repeat (burst) begin
                if (k == 400) hold_pop = 1'b1;
                send_word(rand_word());
                k++;
            end
            if ($urandom_range(0, 2) != 0) begin
                push <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
        idle_send();
        stim_done = 1'b1;
    end

    // Receiver: random stalls, plus one long hold-off to fill the block.
    initial begin
        int phase;
        phase = 0;
        forever begin
            @(posedge i_clk);
            if (hold_pop) begin
                pop <= 1'b0;
                repeat (300) @(posedge i_clk);
                hold_pop = 1'b0;
            end
            phase++;
            pop <= ((phase / 64) % 2 == 0) ? 1'b1 : ($urandom_range(0, 3) != 0);
        end
    end

    // Compare each accepted result with the oldest expectation.
    always @(posedge i_clk) begin
        t_out_word exp_w;
        if (i_rst_n && (push && !full || pop && !empty)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (i_rst_n && pop && !empty) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result word %h", o_result);
                fail_count++;
            end else begin
                exp_w = pending_results.pop_front();
                if (o_result.result_low !== exp_w.result_low) begin
                    $error("result_low expected %h actual %h", exp_w.result_low,
                           o_result.result_low); fail_count++;
                end
                if (o_result.result_high !== exp_w.result_high) begin
                    $error("result_high expected %h actual %h", exp_w.result_high,
                           o_result.result_high); fail_count++;
                end
                if (o_result.carry_out !== exp_w.carry_out) begin
                    $error("carry_out expected %b actual %b", exp_w.carry_out,
                           o_result.carry_out); fail_count++;
                end
                if (o_result.zero_out !== exp_w.zero_out) begin
                    $error("zero_out expected %b actual %b", exp_w.zero_out,
                           o_result.zero_out); fail_count++;
                end
                if (o_result.sign_out !== exp_w.sign_out) begin
                    $error("sign_out expected %b actual %b", exp_w.sign_out,
                           o_result.sign_out); fail_count++;
                end
                if (o_result.overflow_out !== exp_w.overflow_out) begin
                    $error("overflow_out expected %b actual %b", exp_w.overflow_out,
                           o_result.overflow_out); fail_count++;
                end
                if (o_result.status !== exp_w.status) begin
                    $error("status expected %0d actual %0d", exp_w.status,
                           o_result.status); fail_count++;
                end
            end
        end
    end

    // End of run and watchdog.
    initial begin
        wait (stim_done);
        while (pending_results.size() != 0 && idle_cycles < 2000) @(posedge i_clk);
        if (idle_cycles >= 2000) begin
            $display("tb_top failed");
        end else begin
            repeat (80) @(posedge i_clk);
            if (fail_count == 0 && pending_results.size() == 0) begin
                $display("tb_top passed");
            end else begin
                $display("tb_top failed");
            end
        end
        $finish;
    end

    initial begin
        wait (idle_cycles >= 2000 && !stim_done);
        $display("tb_top failed");
        $finish;
    end

endmodule
